FILE: rtl/btree_node_engine_unit_defines.svh
// Assertion macros for the B-tree node engine.
// Depends on nothing; included by the top level.
`ifndef BTREE_NODE_ENGINE_UNIT_DEFINES_SVH
`define BTREE_NODE_ENGINE_UNIT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define BNE_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define BNE_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

FILE: rtl/bne_pkg.sv
// Types and constants shared by the B-tree node engine.
// No dependencies.
package bne_pkg;
  localparam int ORDER_DEF = 8;
  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_LEFT   = 3'd1;
  localparam logic [2:0] CMD_INSERT = 3'd2;
  localparam logic [2:0] CMD_SEARCH = 3'd3;
  localparam logic [2:0] CMD_SPLIT  = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_FOUND   = 3'd1;
  localparam logic [2:0] ST_DESCEND = 3'd2;
  localparam logic [2:0] ST_REJECT  = 3'd3;
  localparam logic [2:0] ST_PROMOTE = 3'd4;
  localparam logic [2:0] ST_MOVED   = 3'd5;
  localparam logic signed [31:0] CHILD_NONE = -32'sd1;

  typedef struct packed {
    logic [2:0]         command;
    logic [30:0]        key_id;
    logic [47:0]        key_offset;
    logic signed [31:0] child;
    logic [7:0]         height;
  } bne_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [30:0]        out_key_id;
    logic [47:0]        out_offset;
    logic signed [31:0] out_child;
    logic [2:0]         key_count;
    logic               is_full;
    logic [7:0]         node_height;
    logic               last;
  } bne_out_t;

  // Per-cell payload: key and the child to its right.
  typedef struct packed {
    logic [30:0]        id;
    logic [47:0]        off;
    logic signed [31:0] ch;
  } bne_slot_t;

  // Controls broadcast along the row each cycle.
  typedef struct packed {
    logic       shift;     // move toward higher slot where enabled
    logic       load;      // write new key at the chosen slot
    logic       shl;       // move toward lower slot (drain for split)
    logic       clr_ch;    // set children to none
    bne_slot_t  new_slot;
  } bne_ctl_t;
endpackage

FILE: rtl/btree_node_engine_unit.sv
// B-tree node engine: row of ORDER cells with a small sequencer.
// Clear, left and rejected commands answer from idle; insert goes through S_INS; search scans one key per cycle;
// split rotates the row through S_DRN, then S_EMIT gives one beat per cycle, promoted key first, last beat flagged.
// One command at a time; busy stays high until the last beat.
// Reset (rst, synchronous): count and height zero, children none, idle.
// Depends on bne_pkg, bne_cell and btree_node_engine_unit_defines.svh.
`include "btree_node_engine_unit_defines.svh"
module btree_node_engine_unit import bne_pkg::*; #(
  parameter int ORDER = ORDER_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  bne_in_t  cmd,
  output logic     busy,
  output logic     valid,
  output bne_out_t result
);
  localparam int HALF = (ORDER - 1) / 2;
  localparam int CW = $clog2(ORDER + 1);
  localparam int IW = $clog2(ORDER);
  localparam logic [2:0] S_IDLE = 3'd0, S_INS = 3'd1, S_SRCH = 3'd2,
                         S_DRN = 3'd3, S_EMIT = 3'd4;

  logic [2:0]      state;
  logic [CW-1:0]   count;
  logic [7:0]      level;
  logic signed [31:0] child0;
  bne_in_t         item;
  logic [CW-1:0]   idx;
  bne_ctl_t        ctl;
  bne_slot_t       slots [ORDER];
  logic [ORDER-1:0] ge_new;
  logic [ORDER-1:0] sel_shift, sel_load;
  bne_slot_t       head;
  bne_slot_t       wrap;
  logic            full;

  assign full = (count >= CW'(ORDER - 1));
  assign busy = (state != S_IDLE);
  assign head = slots[0];

  // Insert position: cells holding a key greater than the new id shift up;
  // the new key lands in the first such cell, or right after the last key.
  always_comb begin
    for (int i = 0; i < ORDER; i++) begin
      ge_new[i] = (CW'(i) < count) && (slots[i].id > item.key_id);
    end
    sel_shift[0] = 1'b0;
    sel_load[0]  = (count == '0) || ge_new[0];
    for (int i = 1; i < ORDER; i++) begin
      sel_shift[i] = ge_new[i - 1];
      sel_load[i]  = !ge_new[i - 1] && ((CW'(i) == count) || ge_new[i]);
    end
  end

  // Head wraps to the top cell; moved keys come back with no child.
  always_comb begin
    wrap = slots[0];
    if (state == S_EMIT) wrap.ch = CHILD_NONE;
  end

  // Row of cells; neighbors pass data both ways, downward moves rotate.
  for (genvar g = 0; g < ORDER; g++) begin : g_row
    bne_slot_t lo, hi;
    assign lo = (g == 0) ? slots[0] : slots[(g == 0) ? 0 : g - 1];
    assign hi = (g == ORDER - 1) ? wrap : slots[(g == ORDER - 1) ? g : g + 1];
    bne_cell u_cell (
      .clk, .rst, .ctl,
      .sel_shift(sel_shift[g]),
      .sel_load (sel_load[g]),
      .from_lo(lo), .from_hi(hi),
      .slot(slots[g])
    );
  end

  // Result beat builder.
  function automatic bne_out_t mk(input logic [2:0] st, input logic [30:0] id,
                                  input logic [47:0] off, input logic signed [31:0] ch,
                                  input logic [CW-1:0] cnt, input logic [7:0] lv,
                                  input logic lst);
    bne_out_t r;
    r.status = st; r.out_key_id = id; r.out_offset = off; r.out_child = ch;
    r.key_count = cnt[2:0]; r.is_full = (cnt >= CW'(ORDER - 1));
    r.node_height = lv; r.last = lst;
    return r;
  endfunction

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; count <= '0; level <= '0; child0 <= CHILD_NONE;
      valid <= 1'b0; idx <= '0;
    end else begin
      valid <= 1'b0;
      case (state)
        S_IDLE: if (start) begin
          item <= cmd;
          idx <= '0;
          case (cmd.command)
            CMD_CLEAR: begin
              count <= '0; level <= cmd.height; child0 <= CHILD_NONE;
              valid <= 1'b1;
              result <= mk(ST_DONE, '0, '0, '0, '0, cmd.height, 1'b1);
            end
            CMD_LEFT: begin
              child0 <= cmd.child; valid <= 1'b1;
              result <= mk(ST_DONE, '0, '0, '0, count, level, 1'b1);
            end
            CMD_INSERT: begin
              if (full) begin
                valid <= 1'b1;
                result <= mk(ST_REJECT, '0, '0, '0, count, level, 1'b1);
              end else state <= S_INS;
            end
            CMD_SEARCH: state <= S_SRCH;
            CMD_SPLIT: begin
              if (!full) begin
                valid <= 1'b1;
                result <= mk(ST_REJECT, '0, '0, '0, count, level, 1'b1);
              end else state <= S_INS;
            end
            default: begin
              valid <= 1'b1;
              result <= mk(ST_REJECT, '0, '0, '0, count, level, 1'b1);
            end
          endcase
        end
        S_INS: begin
          if (item.command == CMD_SPLIT) begin
            count <= CW'(HALF);
            idx <= '0;
            state <= S_DRN;
          end else begin
            count <= count + 1'b1;
            valid <= 1'b1;
            result <= mk(ST_DONE, '0, '0, '0, count + 1'b1, level, 1'b1);
            state <= S_IDLE;
          end
        end
        S_SRCH: begin
          if (idx < count && slots[idx[IW-1:0]].id == item.key_id) begin
            valid <= 1'b1; state <= S_IDLE;
            result <= mk(ST_FOUND, '0, slots[idx[IW-1:0]].off, '0, count, level, 1'b1);
          end else if (idx < count && slots[idx[IW-1:0]].id > item.key_id) begin
            valid <= 1'b1; state <= S_IDLE;
            result <= mk(ST_DESCEND, '0, '0,
                         (idx == '0) ? child0 : slots[IW'(idx - 1'b1)].ch,
                         count, level, 1'b1);
          end else if (idx >= count) begin
            valid <= 1'b1; state <= S_IDLE;
            result <= mk(ST_DESCEND, '0, '0,
                         (idx == '0) ? child0 : slots[IW'(idx - 1'b1)].ch,
                         count, level, 1'b1);
          end else idx <= idx + 1'b1;
        end
        S_DRN: begin
          // rotate the row down HALF times so the promoted key reaches the head
          if (idx == CW'(HALF)) begin
            idx <= '0; state <= S_EMIT;
          end else idx <= idx + 1'b1;
        end
        S_EMIT: begin
          // one more rotation per beat; after ORDER in all the kept keys are home
          valid <= 1'b1;
          result <= mk((idx == '0) ? ST_PROMOTE : ST_MOVED, head.id, head.off, head.ch,
                       count, level, idx == CW'(ORDER - 1 - HALF));
          if (idx == CW'(ORDER - 1 - HALF)) state <= S_IDLE;
          else idx <= idx + 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Row controls.
  always_comb begin
    ctl = '0;
    ctl.new_slot.id  = item.key_id;
    ctl.new_slot.off = item.key_offset;
    ctl.new_slot.ch  = item.child;
    ctl.shift = (state == S_INS);
    ctl.load  = (state == S_INS);
    ctl.shl   = (state == S_DRN && idx != CW'(HALF)) || (state == S_EMIT);
    ctl.clr_ch = (state == S_IDLE && start && cmd.command == CMD_CLEAR);
  end

  `BNE_ASSERT_IMP(a_busy_cnt, clk, rst, !busy, count <= CW'(ORDER - 1))
  `BNE_ASSERT_NEXT(a_acc_busy, clk, rst, start && !busy && cmd.command == CMD_SEARCH, busy)
endmodule

FILE: rtl/bne_cell.sv
// One slot of the node row: key id, offset and right child.
// Depends on bne_pkg.
module bne_cell import bne_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  bne_ctl_t  ctl,
  input  logic      sel_shift,  // this cell takes its lower neighbor
  input  logic      sel_load,   // this cell takes the new key
  input  bne_slot_t from_lo,
  input  bne_slot_t from_hi,
  output bne_slot_t slot
);
  logic [30:0]        id;
  logic [47:0]        off;
  logic signed [31:0] ch;

  // Key storage; child resets to none.
  always_ff @(posedge clk) begin
    if (rst) begin
      ch <= CHILD_NONE;
    end else if (ctl.clr_ch) begin
      ch <= CHILD_NONE;
    end else if (ctl.load && sel_load) begin
      ch <= ctl.new_slot.ch;
    end else if (ctl.shift && sel_shift) begin
      ch <= from_lo.ch;
    end else if (ctl.shl) begin
      ch <= from_hi.ch;
    end
  end
  always_ff @(posedge clk) begin
    if (ctl.load && sel_load) begin
      id  <= ctl.new_slot.id;
      off <= ctl.new_slot.off;
    end else if (ctl.shift && sel_shift) begin
      id  <= from_lo.id;
      off <= from_lo.off;
    end else if (ctl.shl) begin
      id  <= from_hi.id;
      off <= from_hi.off;
    end
  end

  assign slot = {id, off, ch};
endmodule
